[src/whacc_pkg.sv]
// ----------------------------------------------------------------------------
// whacc_pkg: shared definitions for the weighted histogram accumulator
// Opcodes, region codes, register indexes and default sizes used by the unit.
// ----------------------------------------------------------------------------
package whacc_pkg;

    // default sizes of the bin store and of the sums
    localparam int MAX_BINS_DEF = 256;
    localparam int SUM_BITS_DEF = 48;

    // fixed field widths of the stream payload
    localparam int SAMPLE_W  = 16;
    localparam int WEIGHT_W  = 16;
    localparam int SELECT_W  = 8;
    localparam int INDEX_W   = 8;
    localparam int OUT_SUM_W = 48;
    localparam int COUNT_W   = 32;
    localparam int BINS_W    = 9;

    // item opcodes
    localparam logic [1:0] OP_OBSERVE = 2'd0;
    localparam logic [1:0] OP_CLEAR   = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    // result regions
    localparam logic [1:0] REGION_BIN   = 2'd0;
    localparam logic [1:0] REGION_BELOW = 2'd1;
    localparam logic [1:0] REGION_ABOVE = 2'd2;
    localparam logic [1:0] REGION_NONE  = 2'd3;

    // register indexes (byte address 4 * index)
    localparam logic [1:0] REG_RANGE_LOW   = 2'd0;
    localparam logic [1:0] REG_BIN_WIDTH   = 2'd1;
    localparam logic [1:0] REG_BINS_IN_USE = 2'd2;

    // reset values of the registers
    localparam logic [15:0]       RANGE_LOW_RST   = 16'd0;
    localparam logic [15:0]       BIN_WIDTH_RST   = 16'd1;
    localparam logic [BINS_W-1:0] BINS_IN_USE_RST = 9'd256;

endpackage

[src/weighted_histogram_accumulator_unit.sv]
// ----------------------------------------------------------------------------
// weighted_histogram_accumulator_unit: weighted histogram with under/overflow
// Serial divider finds the bin, one saturating adder updates every sum.
// ----------------------------------------------------------------------------
// order: an observe in a bin runs S_GRAND, S_DIV, S_CHECK, S_FETCH, S_BIN,
//   S_DONE; above range S_GRAND, S_DIV, S_CHECK, S_ABOVE, S_DONE; below range
//   S_GRAND, S_BELOW, S_DONE; a read S_FETCH, S_RDOUT, S_DONE; a clear S_CLR, S_DONE
// throughput: one item at a time, the next beat is taken in the cycle after the result loads; the 16-step divider
//   runs for an observe at or above range; a result waits while the output register is still full
// reset: registers take their reset values, then a sweep zeroes every entry of
//   the bin store with s_axis_tready low; every write to a defined register sweeps again
module weighted_histogram_accumulator_unit #(
    parameter int MAX_BINS = whacc_pkg::MAX_BINS_DEF,
    parameter int SUM_BITS = whacc_pkg::SUM_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,   // sample[15:0], weight[31:16], bin_select[39:32]
    input  logic [1:0]   s_axis_tuser,   // opcode[1:0]
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [231:0] m_axis_tdata,   // bin_index[7:0], bin_weight[55:8],
                                         // weight_below[103:56], weight_above[151:104],
                                         // total_weight[199:152], observation_count[231:200]
    output logic [1:0]   m_axis_tuser,   // region[1:0]
    // register port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int SW = whacc_pkg::SAMPLE_W;
    localparam int WW = whacc_pkg::WEIGHT_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_GRAND,
        S_BELOW,
        S_DIV,
        S_CHECK,
        S_ABOVE,
        S_FETCH,
        S_BIN,
        S_RDOUT,
        S_DONE
    } t_state;

    t_state r_state;

    // configuration registers
    logic [15:0]                   r_range_low;
    logic [15:0]                   r_bin_width;
    logic [whacc_pkg::BINS_W-1:0]  r_bins_in_use;

    // sums and count
    logic [SUM_BITS-1:0]           r_grand;
    logic [SUM_BITS-1:0]           r_below;
    logic [SUM_BITS-1:0]           r_above;
    logic [whacc_pkg::COUNT_W-1:0] r_count;

    // item under work
    logic [1:0]                    r_op;
    logic [WW-1:0]                 r_weight;
    logic [SW-1:0]                 r_off;
    logic                          r_is_below;
    logic                          r_sel_ok;
    logic [SW-1:0]                 r_quot;
    logic [SW-1:0]                 r_rem;
    logic [3:0]                    r_div_cnt;
    logic [AW-1:0]                 r_addr;
    logic [AW-1:0]                 r_clr_cnt;
    logic                          r_clr_emit;

    // result under construction
    logic [1:0]                    r_res_region;
    logic [whacc_pkg::INDEX_W-1:0] r_res_index;
    logic [SUM_BITS-1:0]           r_res_bw;

    // output register
    logic                            r_m_valid;
    logic [1:0]                      r_o_region;
    logic [whacc_pkg::INDEX_W-1:0]   r_o_index;
    logic [whacc_pkg::OUT_SUM_W-1:0] r_o_bw;
    logic [whacc_pkg::OUT_SUM_W-1:0] r_o_below;
    logic [whacc_pkg::OUT_SUM_W-1:0] r_o_above;
    logic [whacc_pkg::OUT_SUM_W-1:0] r_o_total;
    logic [whacc_pkg::COUNT_W-1:0]   r_o_count;

    // bin store
    logic [SUM_BITS-1:0] bin_mem [MAX_BINS];
    logic [SUM_BITS-1:0] r_rd_data;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [SUM_BITS-1:0] mem_wdata;

    logic                in_accept;
    logic                out_take;
    logic                cfg_write;
    logic                cfg_hit;
    logic [1:0]          cfg_index;
    logic [SW:0]         diff;
    logic [SUM_BITS-1:0] add_a;
    logic [SUM_BITS:0]   add_full;
    logic [SUM_BITS-1:0] sat_sum;
    logic [SW:0]         div_shift;
    logic [SW+1:0]       div_trial;
    logic [31:0]         active_bins;
    logic                in_range;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_take  = r_m_valid && m_axis_tready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[3:2];
    assign cfg_hit   = cfg_write && (cfg_index == whacc_pkg::REG_RANGE_LOW ||
                                     cfg_index == whacc_pkg::REG_BIN_WIDTH ||
                                     cfg_index == whacc_pkg::REG_BINS_IN_USE);

    // offset of the sample from the lower edge, sign marks below range
    assign diff = {s_axis_tdata[SW-1], s_axis_tdata[SW-1:0]} - {r_range_low[SW-1], r_range_low};

    // shared saturating adder
    always_comb begin
        case (r_state)
            S_BELOW: add_a = r_below;
            S_ABOVE: add_a = r_above;
            S_BIN:   add_a = r_rd_data;
            default: add_a = r_grand;
        endcase
    end
    assign add_full = {1'b0, add_a} + (SUM_BITS + 1)'(r_weight);
    assign sat_sum  = add_full[SUM_BITS] ? '1 : add_full[SUM_BITS-1:0];

    // one restoring division step
    assign div_shift = {r_rem, r_quot[SW-1]};
    assign div_trial = {1'b0, div_shift} - {2'b00, r_bin_width};

    // active bin count, limited to the store depth
    assign active_bins = (32'(r_bins_in_use) > MAX_BINS) ? 32'(MAX_BINS)
                                                         : 32'(r_bins_in_use);
    assign in_range = 32'(r_quot) < active_bins;

    // bin store write port: sweep or bin update
    assign mem_we    = (r_state == S_CLR) || (r_state == S_BIN);
    assign mem_waddr = (r_state == S_CLR) ? r_clr_cnt : r_addr;
    assign mem_wdata = (r_state == S_CLR) ? '0 : sat_sum;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            bin_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= bin_mem[r_addr];
    end

    // sequencer, sums and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLR;
            r_clr_cnt     <= '0;
            r_clr_emit    <= 1'b0;
            r_range_low   <= whacc_pkg::RANGE_LOW_RST;
            r_bin_width   <= whacc_pkg::BIN_WIDTH_RST;
            r_bins_in_use <= whacc_pkg::BINS_IN_USE_RST;
            r_grand       <= '0;
            r_below       <= '0;
            r_above       <= '0;
            r_count       <= '0;
            r_m_valid     <= 1'b0;
            r_div_cnt     <= '0;
        end else begin
            // result beat leaves the output register unless a new one loads
            if (out_take && (cfg_hit || r_state != S_DONE)) begin
                r_m_valid <= 1'b0;
            end

            if (cfg_hit) begin
                // register write: redefines the bins, so all sums clear
                unique case (cfg_index)
                    whacc_pkg::REG_RANGE_LOW:   r_range_low   <= pwdata[15:0];
                    whacc_pkg::REG_BIN_WIDTH:   r_bin_width   <= pwdata[15:0];
                    default:                    r_bins_in_use <= pwdata[whacc_pkg::BINS_W-1:0];
                endcase
                r_grand   <= '0;
                r_below   <= '0;
                r_above   <= '0;
                r_count   <= '0;
                r_clr_cnt <= '0;
                if (r_state != S_CLR) begin
                    r_clr_emit <= 1'b0;
                end
                r_state   <= S_CLR;
            end else begin
                unique case (r_state)
                    S_IDLE: begin
                        if (in_accept) begin
                            r_op        <= s_axis_tuser;
                            r_weight    <= s_axis_tdata[2*SW-1:SW];
                            r_off       <= diff[SW-1:0];
                            r_is_below  <= diff[SW];
                            r_res_index <= '0;
                            r_res_bw    <= '0;
                            case (s_axis_tuser)
                                whacc_pkg::OP_OBSERVE: begin
                                    r_state <= S_GRAND;
                                end
                                whacc_pkg::OP_CLEAR: begin
                                    r_res_region <= whacc_pkg::REGION_NONE;
                                    r_grand      <= '0;
                                    r_below      <= '0;
                                    r_above      <= '0;
                                    r_count      <= '0;
                                    r_clr_cnt    <= '0;
                                    r_clr_emit   <= 1'b1;
                                    r_state      <= S_CLR;
                                end
                                default: begin
                                    // read, the unused code reads too
                                    r_res_region <= whacc_pkg::REGION_NONE;
                                    r_res_index  <=
                                        s_axis_tdata[2*SW+whacc_pkg::SELECT_W-1:2*SW];
                                    r_addr       <=
                                        AW'(s_axis_tdata[2*SW+whacc_pkg::SELECT_W-1:2*SW]);
                                    r_sel_ok     <=
                                        32'(s_axis_tdata[2*SW+whacc_pkg::SELECT_W-1:2*SW])
                                        < MAX_BINS;
                                    r_state      <= S_FETCH;
                                end
                            endcase
                        end
                    end
                    S_CLR: begin
                        r_clr_cnt <= r_clr_cnt + 1'b1;
                        if (r_clr_cnt == AW'(MAX_BINS - 1)) begin
                            r_state <= r_clr_emit ? S_DONE : S_IDLE;
                        end
                    end
                    S_GRAND: begin
                        r_grand   <= sat_sum;
                        r_count   <= (r_count != '1) ? r_count + 1'b1 : r_count;
                        r_quot    <= r_off;
                        r_rem     <= '0;
                        r_div_cnt <= '0;
                        r_state   <= r_is_below ? S_BELOW : S_DIV;
                    end
                    S_BELOW: begin
                        r_below      <= sat_sum;
                        r_res_region <= whacc_pkg::REGION_BELOW;
                        r_state      <= S_DONE;
                    end
                    S_DIV: begin
                        r_quot    <= {r_quot[SW-2:0], ~div_trial[SW+1]};
                        r_rem     <= div_trial[SW+1] ? div_shift[SW-1:0] : div_trial[SW-1:0];
                        r_div_cnt <= r_div_cnt + 1'b1;
                        if (r_div_cnt == 4'(SW - 1)) begin
                            r_state <= S_CHECK;
                        end
                    end
                    S_CHECK: begin
                        if (in_range) begin
                            r_addr  <= AW'(r_quot);
                            r_state <= S_FETCH;
                        end else begin
                            r_state <= S_ABOVE;
                        end
                    end
                    S_ABOVE: begin
                        r_above      <= sat_sum;
                        r_res_region <= whacc_pkg::REGION_ABOVE;
                        r_state      <= S_DONE;
                    end
                    S_FETCH: begin
                        r_state <= (r_op == whacc_pkg::OP_OBSERVE) ? S_BIN : S_RDOUT;
                    end
                    S_BIN: begin
                        r_res_region <= whacc_pkg::REGION_BIN;
                        r_res_index  <= r_quot[whacc_pkg::INDEX_W-1:0];
                        r_res_bw     <= sat_sum;
                        r_state      <= S_DONE;
                    end
                    S_RDOUT: begin
                        r_res_bw <= r_sel_ok ? r_rd_data : '0;
                        r_state  <= S_DONE;
                    end
                    S_DONE: begin
                        if (!r_m_valid || m_axis_tready) begin
                            r_m_valid  <= 1'b1;
                            r_o_region <= r_res_region;
                            r_o_index  <= r_res_index;
                            r_o_bw     <= whacc_pkg::OUT_SUM_W'(r_res_bw);
                            r_o_below  <= whacc_pkg::OUT_SUM_W'(r_below);
                            r_o_above  <= whacc_pkg::OUT_SUM_W'(r_above);
                            r_o_total  <= whacc_pkg::OUT_SUM_W'(r_grand);
                            r_o_count  <= r_count;
                            r_state    <= S_IDLE;
                        end
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end
        end
    end

    // register read-back
    always_comb begin
        unique case (cfg_index)
            whacc_pkg::REG_RANGE_LOW:   prdata = 32'(r_range_low);
            whacc_pkg::REG_BIN_WIDTH:   prdata = 32'(r_bin_width);
            whacc_pkg::REG_BINS_IN_USE: prdata = 32'(r_bins_in_use);
            default:                    prdata = '0;
        endcase
    end

    assign pready        = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_o_region;
    assign m_axis_tdata  = {r_o_count, r_o_total, r_o_above, r_o_below, r_o_bw, r_o_index};

    // a clear beat leaves the totals at zero
    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && s_axis_tuser == whacc_pkg::OP_CLEAR)
        |=> (r_grand == '0 && r_count == '0 && r_below == '0 && r_above == '0))
        else $error("totals not cleared after clear beat");

    // every weight goes to the grand sum, so it bounds the side sums
    a_grand_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_grand >= r_below && r_grand >= r_above))
        else $error("grand sum below an underflow or overflow sum");

    // an accepted beat always starts work
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state != S_IDLE))
        else $error("sequencer stayed idle after accepting a beat");

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the weighted histogram accumulator
// Streams observe, clear and read beats through the unit under several bin
// settings, keeps its own histogram to predict each result beat and compares
// every field of every result beat against that prediction.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [1:0] OP_SPARE = 2'd3;   // unused opcode, decodes as a read
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 150;
    localparam int SETTLE_CYCLES = 25;
    localparam int DRAIN_CYCLES = 300;
    localparam int PHASE_ITEMS  = 210;
    localparam int NUM_PHASES   = 8;

    typedef struct packed {
        logic [1:0]                     op;
        logic [whacc_pkg::SAMPLE_W-1:0] sample_val;
        logic [whacc_pkg::WEIGHT_W-1:0] weight;
        logic [whacc_pkg::SELECT_W-1:0] sel;
    } t_hist_item;

    typedef struct packed {
        logic [1:0]                      region;
        logic [whacc_pkg::INDEX_W-1:0]   index;
        logic [whacc_pkg::OUT_SUM_W-1:0] bin_weight;
        logic [whacc_pkg::OUT_SUM_W-1:0] below;
        logic [whacc_pkg::OUT_SUM_W-1:0] above;
        logic [whacc_pkg::OUT_SUM_W-1:0] total;
        logic [whacc_pkg::COUNT_W-1:0]   count;
    } t_hist_result;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [39:0]   s_axis_tdata = '0;    // sample[15:0], weight[31:16], bin_select[39:32]
    logic [1:0]    s_axis_tuser = '0;    // opcode[1:0]
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [231:0]  m_axis_tdata;         // bin_index[7:0], bin_weight[55:8],
                                         // weight_below[103:56], weight_above[151:104],
                                         // total_weight[199:152], observation_count[231:200]
    logic [1:0]    m_axis_tuser;         // region[1:0]
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [3:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;

    weighted_histogram_accumulator_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // local copy of the registers and the histogram
    logic [15:0]                     cfg_low   = whacc_pkg::RANGE_LOW_RST;
    logic [15:0]                     cfg_width = whacc_pkg::BIN_WIDTH_RST;
    logic [whacc_pkg::BINS_W-1:0]    cfg_bins  = whacc_pkg::BINS_IN_USE_RST;
    logic [whacc_pkg::OUT_SUM_W-1:0] bin_sums [whacc_pkg::MAX_BINS_DEF];
    logic [whacc_pkg::OUT_SUM_W-1:0] below_sum, above_sum, grand_sum;
    logic [whacc_pkg::COUNT_W-1:0]   obs_count;

    t_hist_item   pending_items[$];
    t_hist_result predicted_results[$];

    int idle_pct = 0;
    int gap_left = 0;
    int stall_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int result_beats = 0;
    int cycles = 0;
    int mismatches = 0;
    int n_items = 0, n_binned = 0, n_below = 0, n_above = 0, n_reads = 0, n_clears = 0;
    int n_reg_writes = 0;

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [whacc_pkg::OUT_SUM_W-1:0] sat_add(
        input logic [whacc_pkg::OUT_SUM_W-1:0] acc,
        input logic [whacc_pkg::WEIGHT_W-1:0]  w);
        logic [whacc_pkg::OUT_SUM_W:0] s;
        s = {1'b0, acc} + w;
        return s[whacc_pkg::OUT_SUM_W] ? {whacc_pkg::OUT_SUM_W{1'b1}}
                                       : s[whacc_pkg::OUT_SUM_W-1:0];
    endfunction

    function automatic void clear_histogram();
        foreach (bin_sums[i]) bin_sums[i] = '0;
        below_sum = '0;
        above_sum = '0;
        grand_sum = '0;
        obs_count = '0;
    endfunction

    function automatic int active_bins();
        return (cfg_bins > whacc_pkg::MAX_BINS_DEF) ? whacc_pkg::MAX_BINS_DEF : int'(cfg_bins);
    endfunction

    // histogram update for one accepted beat, returns the result it causes
    function automatic t_hist_result accumulate(input t_hist_item it);
        t_hist_result r;
        logic signed [16:0] offset;
        logic [15:0] quot;
        r = '0;
        r.region = whacc_pkg::REGION_NONE;
        n_items++;
        case (it.op)
            whacc_pkg::OP_OBSERVE: begin
                if (obs_count != {whacc_pkg::COUNT_W{1'b1}}) obs_count++;
                grand_sum = sat_add(grand_sum, it.weight);
                offset = $signed({it.sample_val[15], it.sample_val})
                       - $signed({cfg_low[15], cfg_low});
                if (offset < 0) begin
                    below_sum = sat_add(below_sum, it.weight);
                    r.region = whacc_pkg::REGION_BELOW;
                    n_below++;
                end else begin
                    // zero width behaves as a divider returning all ones
                    quot = (cfg_width == 0) ? 16'hFFFF : offset[15:0] / cfg_width;
                    if (int'(quot) < active_bins()) begin
                        bin_sums[quot[7:0]] = sat_add(bin_sums[quot[7:0]], it.weight);
                        r.region = whacc_pkg::REGION_BIN;
                        r.index = quot[7:0];
                        r.bin_weight = bin_sums[quot[7:0]];
                        n_binned++;
                    end else begin
                        above_sum = sat_add(above_sum, it.weight);
                        r.region = whacc_pkg::REGION_ABOVE;
                        n_above++;
                    end
                end
            end
            whacc_pkg::OP_CLEAR: begin
                clear_histogram();
                n_clears++;
            end
            default: begin
                // read, the spare opcode included
                r.index = it.sel;
                r.bin_weight = bin_sums[it.sel];
                n_reads++;
            end
        endcase
        r.below = below_sum;
        r.above = above_sum;
        r.total = grand_sum;
        r.count = obs_count;
        return r;
    endfunction

    function automatic void queue_item(input logic [1:0] op, input logic [15:0] smp,
                                       input logic [15:0] wt, input logic [7:0] sel);
        t_hist_item it;
        it.op = op;
        it.sample_val = smp;
        it.weight = wt;
        it.sel = sel;
        pending_items.push_back(it);
    endfunction

    // random beat, mostly observes aimed around the active bins
    function automatic t_hist_item random_item();
        t_hist_item it;
        int pick, lo, span, s, nb;
        pick = $urandom_range(99);
        nb = active_bins();
        it.sample_val = 16'($urandom);
        it.sel = 8'($urandom);
        case ($urandom_range(9))
            0: it.weight = '0;
            1: it.weight = '1;
            default: it.weight = 16'($urandom);
        endcase
        if (pick < 68) begin
            it.op = whacc_pkg::OP_OBSERVE;
            if ($urandom_range(9) < 7) begin
                lo = int'($signed(cfg_low));
                span = ((cfg_width == 0) ? 8 : int'(cfg_width)) * ((nb == 0) ? 4 : nb);
                s = lo - 3 + int'($urandom_range(span + 6));
                if (s < -32768 || s > 32767) s = int'($urandom_range(65535)) - 32768;
                it.sample_val = s[15:0];
            end
        end else if (pick < 96) begin
            it.op = (pick < 92) ? whacc_pkg::OP_READ : OP_SPARE;
            if (nb > 0 && $urandom_range(9) < 7) it.sel = 8'($urandom_range(nb - 1));
        end else begin
            it.op = whacc_pkg::OP_CLEAR;
        end
        return it;
    endfunction

    task automatic check_field(input string name,
                               input logic [whacc_pkg::OUT_SUM_W-1:0] exp_v,
                               input logic [whacc_pkg::OUT_SUM_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // register write, setup then access, mirrored into the local copy
    task automatic reg_write(input logic [1:0] idx, input logic [15:0] val);
        logic [31:0] mask, word;
        mask = (idx == whacc_pkg::REG_BINS_IN_USE) ? 32'h1FF : 32'hFFFF;
        word = ($urandom & ~mask) | (32'(val) & mask);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            whacc_pkg::REG_RANGE_LOW: cfg_low   = word[15:0];
            whacc_pkg::REG_BIN_WIDTH: cfg_width = word[15:0];
            default:                  cfg_bins  = word[whacc_pkg::BINS_W-1:0];
        endcase
        clear_histogram();
        n_reg_writes++;
    endtask

    task automatic wait_drained(input int extra);
        while (pending_items.size() != 0 || predicted_results.size() != 0) @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    // input driver: offers the oldest pending beat, random gap bursts between beats
    always @(posedge i_clk) begin
        logic offering;
        t_hist_result res;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            offering = s_axis_tvalid;
            if (offering && s_axis_tready) begin
                res = accumulate(pending_items.pop_front());
                predicted_results.push_back(res);
                offering = 1'b0;
            end
            if (!offering && pending_items.size() != 0) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
                    gap_left = $urandom_range(3);
                end else begin
                    offering = 1'b1;
                end
            end
            s_axis_tvalid <= offering;
            if (offering) begin
                s_axis_tdata <= {pending_items[0].sel, pending_items[0].weight,
                                 pending_items[0].sample_val};
                s_axis_tuser <= pending_items[0].op;
            end
        end
    end

    // result ready: one long hold-off, then random stall bursts
    always @(posedge i_clk) begin
        logic rdy;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) result_beats++;
            rdy = 1'b0;
            if (hold_left > 0) begin
                hold_left--;
            end else if (!hold_done && result_beats >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
            end else if (stall_left > 0) begin
                stall_left--;
            end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
                stall_left = $urandom_range(3);
            end else begin
                rdy = 1'b1;
            end
            m_axis_tready <= rdy;
        end
    end

    // result monitor: compares each result beat with the oldest prediction
    always @(posedge i_clk) begin
        t_hist_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.region     = m_axis_tuser;
            got.index      = m_axis_tdata[7:0];
            got.bin_weight = m_axis_tdata[55:8];
            got.below      = m_axis_tdata[103:56];
            got.above      = m_axis_tdata[151:104];
            got.total      = m_axis_tdata[199:152];
            got.count      = m_axis_tdata[231:200];
            if (predicted_results.size() == 0) begin
                $display("%0t: result beat with nothing expected, expected none, got %h",
                         $time, got);
                mismatches++;
            end else begin
                want = predicted_results.pop_front();
                check_field("region", 48'(want.region), 48'(got.region));
                check_field("bin_index", 48'(want.index), 48'(got.index));
                check_field("bin_weight", want.bin_weight, got.bin_weight);
                check_field("weight_below", want.below, got.below);
                check_field("weight_above", want.above, got.above);
                check_field("total_weight", want.total, got.total);
                check_field("observation_count", 48'(want.count), 48'(got.count));
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    // stimulus sequence
    initial begin
        int ph, k;
        logic [15:0] lo, wd;
        logic [whacc_pkg::BINS_W-1:0] nb;
        clear_histogram();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        idle_pct = 25;

        // directed beats at the reset setting: edges of every field and opcode
        queue_item(whacc_pkg::OP_OBSERVE, 16'h8000, 16'hFFFF, 8'h00); // most negative sample
        queue_item(whacc_pkg::OP_OBSERVE, 16'hFFFF, 16'h0001, 8'hFF); // just below first bin
        queue_item(whacc_pkg::OP_OBSERVE, 16'h0000, 16'hFFFF, 8'h5A); // first bin
        queue_item(whacc_pkg::OP_OBSERVE, 16'h0000, 16'hFFFF, 8'hA5); // first bin again
        queue_item(whacc_pkg::OP_OBSERVE, 16'h00FF, 16'h8000, 8'h00); // last bin
        queue_item(whacc_pkg::OP_OBSERVE, 16'h0100, 16'h7FFF, 8'h00); // just past last bin
        queue_item(whacc_pkg::OP_OBSERVE, 16'h7FFF, 16'h0000, 8'h00); // most positive, no weight
        queue_item(whacc_pkg::OP_OBSERVE, 16'h5555, 16'hAAAA, 8'h00);
        queue_item(whacc_pkg::OP_OBSERVE, 16'h00AA, 16'h5555, 8'h00);
        queue_item(whacc_pkg::OP_READ,    16'hFFFF, 16'hFFFF, 8'h00);
        queue_item(whacc_pkg::OP_READ,    16'h0000, 16'h0000, 8'hFF);
        queue_item(whacc_pkg::OP_READ,    16'h1234, 16'h4321, 8'hAA);
        queue_item(OP_SPARE,              16'h0000, 16'h0000, 8'h55); // spare opcode reads
        queue_item(whacc_pkg::OP_CLEAR,   16'hFFFF, 16'hFFFF, 8'hFF);
        queue_item(whacc_pkg::OP_READ,    16'h0000, 16'h0000, 8'h00); // cleared bin
        queue_item(whacc_pkg::OP_OBSERVE, 16'h0080, 16'd1234, 8'h00);
        queue_item(OP_SPARE,              16'h0000, 16'h0000, 8'h80);
        queue_item(whacc_pkg::OP_CLEAR,   16'h0000, 16'h0000, 8'h00);
        queue_item(whacc_pkg::OP_OBSERVE, 16'h0080, 16'd4321, 8'h80);
        for (k = 0; k < PHASE_ITEMS; k++) pending_items.push_back(random_item());
        wait_drained(SETTLE_CYCLES);

        // one phase per bin setting, each register write also clears the sums
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin lo = 16'h8000; wd = 16'd256;   nb = 9'd256; idle_pct = 40; end
                1: begin lo = 16'h7FFF; wd = 16'd1;     nb = 9'd1;   idle_pct = 0;  end
                2: begin lo = 16'hFF9C; wd = 16'd7;     nb = 9'd37;  idle_pct = 50; end
                3: begin lo = 16'h0000; wd = 16'd0;     nb = 9'd16;  idle_pct = 20; end
                4: begin lo = 16'h8000; wd = 16'hFFFF;  nb = 9'd511; idle_pct = 30; end
                5: begin lo = 16'd1000; wd = 16'd3;     nb = 9'd0;   idle_pct = 10; end
                6: begin
                    lo = 16'($urandom);
                    wd = 16'($urandom_range(1, 300));
                    nb = 9'($urandom_range(1, 256));
                    idle_pct = 35;
                end
                default: begin lo = 16'hFE0C; wd = 16'd13; nb = 9'd64; idle_pct = 0; end
            endcase
            reg_write(whacc_pkg::REG_BIN_WIDTH, wd);
            reg_write(whacc_pkg::REG_RANGE_LOW, lo);
            reg_write(whacc_pkg::REG_BINS_IN_USE, 16'(nb));
            @(negedge i_clk);
            // reads straight after the writes see cleared bins
            queue_item(whacc_pkg::OP_READ, 16'h0000, 16'h0000, 8'h00);
            queue_item(whacc_pkg::OP_READ, 16'h0000, 16'h0000, 8'hC8);
            for (k = 0; k < PHASE_ITEMS; k++) pending_items.push_back(random_item());
            wait_drained((ph == NUM_PHASES - 1) ? DRAIN_CYCLES : SETTLE_CYCLES);
        end

        $display("run covered %0d beats: %0d binned, %0d below, %0d above, %0d reads, %0d clears",
                 n_items, n_binned, n_below, n_above, n_reads, n_clears);
        $display("over %0d register writes and a %0d-cycle hold-off of the result side",
                 n_reg_writes, HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[sim.f]
src/whacc_pkg.sv
src/weighted_histogram_accumulator_unit.sv
test/tb_top.sv
